/* src/cbi_pkg.sv */
// ----------------------------------------------------------------------------
// cbi_pkg
// Types and constants shared by the circular breakpoint interpolator.
// ----------------------------------------------------------------------------
package cbi_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ANGLE_BITS  = 16;
	localparam int NUM_OFFSETS = 10;
	localparam int NUM_BASE    = 9;
	localparam int RATIO_BITS  = 16;

	typedef enum logic [1:0] {
		MODE_BP_WRITE   = 2'd0,
		MODE_BASE_WRITE = 2'd1,
		MODE_QUERY      = 2'd2,
		MODE_NONE       = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_TERM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         row_index;
		logic [3:0]         word_select;
		logic signed [31:0] word_value;
		logic [15:0]        query_angle;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] left_chamfer_angle;
		logic signed [31:0] left_chamfer_length;
		logic signed [31:0] left_groove_angle;
		logic signed [31:0] left_root_face;
		logic signed [31:0] right_chamfer_angle;
		logic signed [31:0] right_chamfer_length;
		logic signed [31:0] right_groove_angle;
		logic signed [31:0] right_root_face;
		logic signed [31:0] center_offset;
		logic signed [31:0] gap_width;
		logic               degenerate_span;
	} result_t;

endpackage

/* src/circular_breakpoint_interpolator.sv */
// ----------------------------------------------------------------------------
// circular_breakpoint_interpolator
// Wrapped piecewise-linear interpolation of ten offsets over a breakpoint table.
// ----------------------------------------------------------------------------
// Writes are taken only while idle; busy stays low. A query keeps busy high
// through the scan of the rows, the bracket and divider steps (a read of the
// last row, a setup, 17 quotient bits), a multiply-add step for each of the ten
// terms, and a finish step; with fewer than two entries the scan goes straight
// to the finish step. The result is strobed in the same cycle in which busy
// falls. The receiver cannot stall. Reset clears the base row, the entry count,
// the state register, the result strobe and the scan counter.
module circular_breakpoint_interpolator
	import cbi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	input  logic    cfg_we,
	input  logic [4:0] cfg_wdata,
	output logic    result_valid,
	output result_t result
);

	localparam int RW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int OAW = $clog2(MAX_ENTRIES * 16);
	localparam int DCW = $clog2(RATIO_BITS + 2);

	// Memories: angles, offsets (row * 16 + offset index), both read through a register.
	logic [ANGLE_BITS-1:0] ang_mem [MAX_ENTRIES];
	logic signed [31:0]    off_mem [MAX_ENTRIES*16];
	logic signed [31:0]    base_q [NUM_BASE];
	logic [4:0]            entries_q;

	state_t state_q, state_d;

	logic [RW-1:0]  ang_raddr;
	logic [ANGLE_BITS-1:0] ang_rdata;
	logic [OAW-1:0] off_raddr;
	logic signed [31:0] off_rdata;

	logic [CW-1:0]  n_q;
	logic [CW-1:0]  scan_q;       // row whose angle is requested
	logic           scan_rv_q;    // read data valid this cycle
	logic [CW-1:0]  scan_row_q;   // row of the data now on ang_rdata
	logic           found_prev_q, found_next_q;
	logic [RW-1:0]  prev_q, next_q;
	logic [ANGLE_BITS-1:0] prev_ang_q, next_ang_q, first_ang_q;
	logic [ANGLE_BITS-1:0] qang_q;

	logic [ANGLE_BITS:0]   rem_q;
	logic [RATIO_BITS:0]   ratio_q;
	logic [ANGLE_BITS-1:0] span_q;
	logic [DCW-1:0] div_cnt_q;
	logic           degen_q;

	logic [3:0]     term_q;
	logic [1:0]     phase_q;
	logic signed [31:0] a_q;
	logic signed [50:0] prod_q;
	logic signed [31:0] res_q [NUM_OFFSETS];
	logic           few_q;

	logic [ANGLE_BITS-1:0] span_w, dist_w, prev_ang_w, next_ang_w;

	// Write port and configuration.
	logic wr_now;
	assign wr_now = start && !busy;

	always_ff @(posedge clk) begin
		if (wr_now && mode_t'(cmd.mode) == MODE_BP_WRITE
			&& 32'(cmd.row_index) < 32'(MAX_ENTRIES)) begin
			if (cmd.word_select == 4'd0)
				ang_mem[cmd.row_index[RW-1:0]] <= cmd.word_value[ANGLE_BITS-1:0];
			else if (cmd.word_select <= 4'(NUM_OFFSETS))
				off_mem[OAW'({cmd.row_index[RW-1:0], cmd.word_select - 4'd1})]
					<= cmd.word_value;
		end
		ang_rdata <= ang_mem[ang_raddr];
		off_rdata <= off_mem[off_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BASE; i++) base_q[i] <= '0;
			entries_q <= '0;
		end else begin
			if (cfg_we) entries_q <= cfg_wdata;
			if (wr_now && mode_t'(cmd.mode) == MODE_BASE_WRITE
				&& cmd.word_select < 4'(NUM_BASE))
				base_q[cmd.word_select] <= cmd.word_value;
		end
	end

	// After the scan the angle port fetches the last row for the wrap below row 0.
	assign ang_raddr = (state_q == ST_SCAN) ? scan_q[RW-1:0] : RW'(n_q - CW'(1));
	always_comb begin
		case (phase_q)
			2'd0:    off_raddr = OAW'({prev_q, term_q});
			default: off_raddr = OAW'({next_q, term_q});
		endcase
	end

	// Bracket result after the scan; ang_rdata holds the last row's angle here.
	assign prev_ang_w = found_prev_q ? prev_ang_q : ang_rdata;
	assign next_ang_w = found_next_q ? next_ang_q : first_ang_q;
	assign span_w = next_ang_w - prev_ang_w;
	assign dist_w = qang_q - prev_ang_w;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (start && mode_t'(cmd.mode) == MODE_QUERY) state_d = ST_SCAN;
			ST_SCAN:
				if (few_q) state_d = ST_DONE;
				else if (scan_rv_q && (scan_row_q == n_q - CW'(1)
					|| ang_rdata > qang_q)) state_d = ST_DIV;
			ST_DIV:
				if (div_cnt_q == DCW'(RATIO_BITS + 2)) state_d = ST_TERM;
			ST_TERM:
				if (phase_q == 2'd3 && term_q == 4'(NUM_OFFSETS - 1)) state_d = ST_DONE;
			ST_DONE:
				state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647)       return 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648) return 32'sh80000000;
		else                           return v[31:0];
	endfunction

	logic signed [50:0] rnd_w;
	logic signed [31:0] base_w;
	logic signed [34:0] term_w;
	logic signed [32:0] diff_w;
	logic [RATIO_BITS:0] ratio_eff_w;
	assign rnd_w = prod_q + 51'sd32768;
	assign term_w = rnd_w[50:16];
	assign diff_w = 33'(off_rdata) - 33'(a_q);
	assign ratio_eff_w = degen_q ? '0 : ratio_q;
	always_comb begin
		if (term_q < 4'd8)      base_w = base_q[term_q];
		else if (term_q == 4'd9) base_w = base_q[8];
		else                    base_w = '0;
	end

	logic [ANGLE_BITS+1:0] trial_w;
	assign trial_w = {1'b0, rem_q} - {2'b00, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
			scan_q <= '0;
			scan_rv_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= (state_q == ST_DONE);
			if (state_q == ST_IDLE) begin
				scan_q <= '0;
				scan_rv_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + CW'(1);
				scan_rv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				qang_q <= cmd.query_angle[ANGLE_BITS-1:0];
				n_q <= (entries_q > 5'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(entries_q);
				few_q <= (entries_q < 5'd2);
				found_prev_q <= 1'b0;
				found_next_q <= 1'b0;
				prev_q <= '0;
				next_q <= '0;
				phase_q <= '0;
				term_q <= '0;
			end
			ST_SCAN: begin
				scan_row_q <= scan_q;
				if (scan_rv_q) begin
					if (scan_row_q == '0) first_ang_q <= ang_rdata;
					if (ang_rdata <= qang_q) begin
						found_prev_q <= 1'b1;
						prev_q <= scan_row_q[RW-1:0];
						prev_ang_q <= ang_rdata;
					end else begin
						found_next_q <= 1'b1;
						next_q <= scan_row_q[RW-1:0];
						next_ang_q <= ang_rdata;
					end
				end
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				if (div_cnt_q == DCW'(1)) begin
					if (!found_prev_q) prev_q <= RW'(n_q - CW'(1));
					if (!found_next_q) next_q <= '0;
					span_q <= span_w;
					degen_q <= (span_w == '0);
					rem_q <= {1'b0, (dist_w > span_w) ? span_w : dist_w};
					ratio_q <= '0;
				end else if (div_cnt_q != '0) begin
					// Restoring division, one quotient bit a cycle, MSB first.
					if (!trial_w[ANGLE_BITS+1]) begin
						rem_q <= {trial_w[ANGLE_BITS-1:0], 1'b0};
						ratio_q <= {ratio_q[RATIO_BITS-1:0], 1'b1};
					end else begin
						rem_q <= {rem_q[ANGLE_BITS-1:0], 1'b0};
						ratio_q <= {ratio_q[RATIO_BITS-1:0], 1'b0};
					end
				end
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			ST_TERM: begin
				phase_q <= phase_q + 2'd1;
				case (phase_q)
					2'd1: a_q <= off_rdata;
					2'd2: prod_q <= diff_w * $signed({1'b0, ratio_eff_w});
					2'd3: begin
						res_q[term_q] <= sat32(36'(base_w) + 36'(a_q) + 36'(term_w));
						term_q <= term_q + 4'd1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		result.left_chamfer_angle   = few_q ? base_q[0] : res_q[0];
		result.left_chamfer_length  = few_q ? base_q[1] : res_q[1];
		result.left_groove_angle    = few_q ? base_q[2] : res_q[2];
		result.left_root_face       = few_q ? base_q[3] : res_q[3];
		result.right_chamfer_angle  = few_q ? base_q[4] : res_q[4];
		result.right_chamfer_length = few_q ? base_q[5] : res_q[5];
		result.right_groove_angle   = few_q ? base_q[6] : res_q[6];
		result.right_root_face      = few_q ? base_q[7] : res_q[7];
		result.center_offset        = few_q ? '0 : res_q[8];
		result.gap_width            = few_q ? base_q[8] : res_q[9];
		result.degenerate_span      = few_q ? 1'b0 : degen_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_DONE))
		else $error("result strobe without finished query");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && cmd.mode == MODE_QUERY) |=> busy)
		else $error("query did not raise busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TERM) |-> (term_q < 4'(NUM_OFFSETS)))
		else $error("term index out of range");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Circular breakpoint interpolator testbench
// Drives breakpoint, base and query commands through the start/busy handshake
// with random gaps, predicts every query result from an in-bench copy of the
// table, and compares each strobed result field by field. The entry count is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb
	import cbi_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 80;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    cfg_we;
	logic [4:0] cfg_wdata;
	logic    result_valid;
	result_t result;

	circular_breakpoint_interpolator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.busy        (busy),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.result_valid(result_valid),
		.result      (result)
	);

	// Shadow copy of the block's table and registers.
	bit [15:0]  shadow_angle [ROWS];
	longint     shadow_offset [ROWS][NUM_OFFSETS];
	longint     shadow_base [NUM_BASE];
	int         shadow_entries;

	cmd_t    pending_cmds [$];
	result_t expected_results [$];
	int      mismatches;
	int      queries_sent;
	int      writes_sent;
	int      config_writes;
	int      gap_left;
	int      quiet_cycles;
	bit      hold_sender;
	bit      no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic result_t interpolate(input bit [15:0] q);
		int     n;
		int     prv;
		int     nxt;
		bit     found_prev;
		bit     found_next;
		bit     degenerate;
		longint span;
		longint dist_len;
		longint ratio;
		longint a;
		longint b;
		longint base;
		longint tot [NUM_OFFSETS];
		result_t r;
		n = (shadow_entries > ROWS) ? ROWS : shadow_entries;
		prv = 0;
		nxt = 0;
		found_prev = 0;
		found_next = 0;
		degenerate = 0;
		if (n < 2) begin
			for (int j = 0; j < 8; j++)
				tot[j] = shadow_base[j];
			tot[8] = 0;
			tot[9] = shadow_base[8];
		end else begin
			for (int i = 0; i < n && !found_next; i++) begin
				if (shadow_angle[i] <= q) begin
					prv = i;
					found_prev = 1;
				end else begin
					nxt = i;
					found_next = 1;
				end
			end
			if (!found_next)
				nxt = 0;
			if (!found_prev)
				prv = n - 1;
			span = (longint'(shadow_angle[nxt]) - longint'(shadow_angle[prv])) & 64'hFFFF;
			dist_len = (longint'(q) - longint'(shadow_angle[prv])) & 64'hFFFF;
			if (span == 0) begin
				degenerate = 1;
				ratio = 0;
			end else begin
				if (dist_len > span)
					dist_len = span;
				ratio = (dist_len << RATIO_BITS) / span;
			end
			for (int j = 0; j < NUM_OFFSETS; j++) begin
				a = shadow_offset[prv][j];
				b = shadow_offset[nxt][j];
				base = 0;
				if (j < 8)
					base = shadow_base[j];
				else if (j == 9)
					base = shadow_base[8];
				// Round half toward plus infinity is a floor after adding one half.
				tot[j] = sat32(base + a + (((b - a) * ratio + 32768) >>> RATIO_BITS));
			end
		end
		r.left_chamfer_angle   = tot[0][31:0];
		r.left_chamfer_length  = tot[1][31:0];
		r.left_groove_angle    = tot[2][31:0];
		r.left_root_face       = tot[3][31:0];
		r.right_chamfer_angle  = tot[4][31:0];
		r.right_chamfer_length = tot[5][31:0];
		r.right_groove_angle   = tot[6][31:0];
		r.right_root_face      = tot[7][31:0];
		r.center_offset        = tot[8][31:0];
		r.gap_width            = tot[9][31:0];
		r.degenerate_span      = degenerate;
		return r;
	endfunction

	task automatic apply_cmd(input cmd_t c);
		case (mode_t'(c.mode))
			MODE_BP_WRITE: begin
				writes_sent++;
				if (c.word_select == 0)
					shadow_angle[c.row_index] = c.word_value[15:0];
				else if (c.word_select <= NUM_OFFSETS)
					shadow_offset[c.row_index][c.word_select - 1] = longint'(c.word_value);
			end
			MODE_BASE_WRITE: begin
				writes_sent++;
				if (c.word_select < NUM_BASE)
					shadow_base[c.word_select] = longint'(c.word_value);
			end
			MODE_QUERY: begin
				queries_sent++;
				expected_results = {expected_results, interpolate(c.query_angle)};
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// Monitor: transfers, result checks and the watchdog, all at the rising edge.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (start && !busy) begin
				apply_cmd(pending_cmds.pop_front());
				gap_left = no_gaps ? 0 : $urandom_range(0, 14);
				quiet_cycles = 0;
			end
			if (result_valid) begin
				quiet_cycles = 0;
				if (expected_results.size() == 0) begin
					report("result strobed with nothing expected");
				end else begin
					want = expected_results.pop_front();
					check_field("left_chamfer_angle", result.left_chamfer_angle,
						want.left_chamfer_angle);
					check_field("left_chamfer_length", result.left_chamfer_length,
						want.left_chamfer_length);
					check_field("left_groove_angle", result.left_groove_angle,
						want.left_groove_angle);
					check_field("left_root_face", result.left_root_face, want.left_root_face);
					check_field("right_chamfer_angle", result.right_chamfer_angle,
						want.right_chamfer_angle);
					check_field("right_chamfer_length", result.right_chamfer_length,
						want.right_chamfer_length);
					check_field("right_groove_angle", result.right_groove_angle,
						want.right_groove_angle);
					check_field("right_root_face", result.right_root_face, want.right_root_face);
					check_field("center_offset", result.center_offset, want.center_offset);
					check_field("gap_width", result.gap_width, want.gap_width);
					check_field("degenerate_span", 32'(result.degenerate_span),
						32'(want.degenerate_span));
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d idle cycles", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Driver: presents the head of the pending queue at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() > 0 && !hold_sender) begin
				start <= 1'b1;
				cmd   <= pending_cmds[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 131072)) - 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_cmd(input mode_t m, input int row, input int word, input logic [31:0] val,
			input logic [15:0] ang);
		cmd_t c;
		c.mode        = m;
		c.row_index   = row[3:0];
		c.word_select = word[3:0];
		c.word_value  = val;
		c.query_angle = ang;
		pending_cmds = {pending_cmds, c};
	endtask

	task automatic query(input logic [15:0] ang);
		push_cmd(MODE_QUERY, $urandom_range(0, 15), $urandom_range(0, 15), $urandom, ang);
	endtask

	// Writes every row in ascending angle order; optionally repeats angles.
	task automatic load_table(input bit with_repeats);
		int angles [$];
		for (int i = 0; i < ROWS; i++)
			angles = {angles, int'($urandom_range(0, 65535))};
		angles.sort();
		if (with_repeats)
			for (int i = 1; i < ROWS; i++)
				if ($urandom_range(0, 2) == 0)
					angles[i] = angles[i - 1];
		for (int i = 0; i < ROWS; i++) begin
			push_cmd(MODE_BP_WRITE, i, 0, {16'($urandom_range(0, 65535)), angles[i][15:0]}, '0);
			for (int w = 1; w <= NUM_OFFSETS; w++)
				push_cmd(MODE_BP_WRITE, i, w, pick_value(), '0);
		end
	endtask

	task automatic drain();
		wait (pending_cmds.size() == 0 && expected_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_entries(input int value);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[4:0];
		@(posedge clk);
		shadow_entries = value & 31;
		config_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Angle of a row as it will stand once the queued writes have gone through.
	function automatic logic [15:0] shadow_next_angle(input int row);
		logic [15:0] a;
		a = shadow_angle[row];
		foreach (pending_cmds[i])
			if (pending_cmds[i].mode == MODE_BP_WRITE && pending_cmds[i].row_index == row
					&& pending_cmds[i].word_select == 0)
				a = pending_cmds[i].word_value[15:0];
		return a;
	endfunction

	task automatic random_mix(input int count);
		int row;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4:
					push_cmd(MODE_BP_WRITE, $urandom_range(0, 15),
						($urandom_range(0, 5) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10),
						pick_value(), 16'($urandom));
				5, 6:
					push_cmd(MODE_BASE_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
						pick_value(), 16'($urandom));
				7:
					push_cmd(MODE_NONE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
						16'($urandom));
				default: begin
					row = $urandom_range(0, 15);
					// Half the queries land on or next to a stored angle.
					if ($urandom_range(0, 1) == 0)
						query(shadow_next_angle(row) + 16'($urandom_range(0, 2)) - 16'd1);
					else
						query(16'($urandom_range(0, 65535)));
				end
			endcase
		end
	endtask

	initial begin
		int phase_entries [];
		phase_entries = '{16, 1, 31, 3, 17, 0, 9, 2, 0};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		gap_left = 0;
		quiet_cycles = 0;
		hold_sender = 1'b0;
		no_gaps = 1'b0;
		mismatches = 0;
		queries_sent = 0;
		writes_sent = 0;
		config_writes = 0;
		shadow_entries = 0;
		foreach (shadow_angle[i])
			shadow_angle[i] = '0;
		foreach (shadow_offset[i, j])
			shadow_offset[i][j] = 0;
		foreach (shadow_base[i])
			shadow_base[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty table: base row straight through, including extreme values.
		write_entries(0);
		query(16'h0000);
		push_cmd(MODE_BASE_WRITE, 0, 0, 32'h7FFF_FFFF, '0);
		push_cmd(MODE_BASE_WRITE, 15, 8, 32'h8000_0000, '0);
		push_cmd(MODE_BASE_WRITE, 0, 12, 32'h1234_5678, '0);
		push_cmd(MODE_NONE, 15, 15, 32'hFFFF_FFFF, 16'hFFFF);
		query(16'hFFFF);
		load_table(1'b0);
		drain();

		// Two entries: wrap below the first, on each angle, and a zero span.
		write_entries(2);
		query(16'h0000);
		query(16'hFFFF);
		query(shadow_angle[0]);
		query(shadow_angle[1]);
		push_cmd(MODE_BP_WRITE, 1, 0, {16'hFFFF, shadow_angle[0]}, '0);
		query(shadow_angle[0]);
		query(16'hFFFF);
		push_cmd(MODE_BP_WRITE, 1, 0, {16'h0000, shadow_angle[0] + 16'd100}, '0);
		query(shadow_angle[0] + 16'd50);

		foreach (phase_entries[p]) begin
			write_entries((p == 8) ? $urandom_range(0, 31) : phase_entries[p]);
			no_gaps = (p % 3 == 1);
			if (p == 2 || p == 5)
				load_table(p == 5);
			random_mix(90);
		end

		drain();
		$display("Covered %0d queries, %0d table writes and %0d entry-count settings.",
			queries_sent, writes_sent, config_writes);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
src/cbi_pkg.sv
src/circular_breakpoint_interpolator.sv
tb/tb.sv
